// ===== rtl/core/bsc_pkg.sv =====
// Shared types, constants and helpers for the BlaBla stream cipher unit.
// No dependencies; every other file in rtl/core refers to this package by scope.
package bsc_pkg;

	// Round schedule: each double round is four half quarter-round phases
	localparam int DOUBLE_ROUNDS = 10;
	localparam int ROUND_CYCLES  = 4 * DOUBLE_ROUNDS;
	localparam int RND_W         = $clog2(ROUND_CYCLES);

	// Configuration register map
	localparam int NUM_REGS  = 6;
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_1 = 3'd5;

	// Byte counts and the last word position in a block
	localparam logic [3:0] BYTES_MIN  = 4'd1;
	localparam logic [3:0] BYTES_FULL = 4'd8;
	localparam logic [3:0] POS_LAST   = 4'd15;

	typedef logic [63:0] word_t;
	typedef logic [15:0][63:0] blk_t;

	// Fixed state words: 0-3 go to state words 0-3, 4-8 to state words 8-12
	localparam word_t FIXED_WORDS [9] = '{
		64'h6170786593810fab, 64'h3320646ec7398aee,
		64'h79622d3217318274, 64'h6b206574babadada,
		64'h2ae36e593e46ad5f, 64'hb68f143029225fc9,
		64'h8da1e08468303aa6, 64'ha48a209acd50a4a7,
		64'h7fdc12f23f90778c
	};

	// Quarter-round word selection a | b<<4 | c<<8 | d<<12; columns then diagonals
	localparam logic [15:0] QR_SEL [8] = '{
		16'hC840, 16'hD951, 16'hEA62, 16'hFB73,
		16'hFA50, 16'hCB61, 16'hD872, 16'hE943
	};

	// Rotate-right amounts, one per byte: 32, 24, 16, 63
	localparam logic [31:0] ROUND_STEPS = 32'h3F101820;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FEED,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       load_item;
		logic       init_state;
		logic       do_round;
		logic [1:0] phase;      // [1] diagonal, [0] second half
		logic       feed_fwd;
		logic       emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic cfg_hit;
		logic block_done;
	} status_t;

	function automatic word_t rotr64(input word_t v, input logic [5:0] n);
		logic [127:0] t;
		t = {v, v} >> n;
		return t[63:0];
	endfunction

endpackage

// ===== rtl/core/bsc_qround.sv =====
// Half of one quarter round: two add / xor / rotate steps on four words.
// Depends on bsc_pkg for word type, rotate amounts and rotate helper.
module bsc_qround (
	input  logic             half,
	input  bsc_pkg::word_t   a,
	input  bsc_pkg::word_t   b,
	input  bsc_pkg::word_t   c,
	input  bsc_pkg::word_t   d,
	output bsc_pkg::word_t   a_nxt,
	output bsc_pkg::word_t   b_nxt,
	output bsc_pkg::word_t   c_nxt,
	output bsc_pkg::word_t   d_nxt
);

	logic [5:0]     rot_d;
	logic [5:0]     rot_b;
	bsc_pkg::word_t sum_a;
	bsc_pkg::word_t mix_d;
	bsc_pkg::word_t sum_c;

	// Pick the rotate pair for this half
	assign rot_d = half ? bsc_pkg::ROUND_STEPS[21:16] : bsc_pkg::ROUND_STEPS[5:0];
	assign rot_b = half ? bsc_pkg::ROUND_STEPS[29:24] : bsc_pkg::ROUND_STEPS[13:8];

	// a += b; d = rotr(d ^ a); c += d; b = rotr(b ^ c)
	assign sum_a = a + b;
	assign mix_d = bsc_pkg::rotr64(d ^ sum_a, rot_d);
	assign sum_c = c + mix_d;

	assign a_nxt = sum_a;
	assign d_nxt = mix_d;
	assign c_nxt = sum_c;
	assign b_nxt = bsc_pkg::rotr64(b ^ sum_c, rot_b);

endmodule

// ===== rtl/core/bsc_datapath.sv =====
// Datapath: config registers, block counter, 16-word working state, four
// half quarter-round units, item and result registers. Depends on bsc_pkg, bsc_qround.
module bsc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                      cfg_data,
	input  logic [63:0]                      data_word,
	input  logic [3:0]                       byte_count,
	input  logic                             last_item,
	input  bsc_pkg::cmd_t                    cmd,
	output bsc_pkg::status_t                 status,
	output logic [63:0]                      result_word,
	output logic [3:0]                       result_count,
	output logic                             result_last
);

	bsc_pkg::word_t cfg_q [bsc_pkg::NUM_REGS];
	bsc_pkg::word_t counter_q;
	bsc_pkg::blk_t  x_q;
	bsc_pkg::blk_t  in_blk;
	bsc_pkg::blk_t  x_rnd;
	logic [3:0]     pos_q;
	bsc_pkg::word_t data_q;
	logic [3:0]     count_q;
	logic           last_q;
	logic [3:0]     count_in;
	bsc_pkg::word_t res_raw;
	bsc_pkg::word_t res_masked;
	bsc_pkg::word_t result_word_q;
	logic [3:0]     result_count_q;
	logic           result_last_q;

	bsc_pkg::word_t lane_a [4];
	bsc_pkg::word_t lane_b [4];
	bsc_pkg::word_t lane_c [4];
	bsc_pkg::word_t lane_d [4];
	bsc_pkg::word_t lane_an [4];
	bsc_pkg::word_t lane_bn [4];
	bsc_pkg::word_t lane_cn [4];
	bsc_pkg::word_t lane_dn [4];
	logic [15:0]    lane_sel [4];

	assign status.cfg_hit    = cfg_we && ({1'b0, cfg_index} < 4'(bsc_pkg::NUM_REGS));
	assign status.block_done = last_q || (pos_q == bsc_pkg::POS_LAST);

	// Build the input state from constants, key, counter and nonce
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			in_blk[i] = bsc_pkg::FIXED_WORDS[i];
		end
		in_blk[4]  = cfg_q[bsc_pkg::REG_KEY_0];
		in_blk[5]  = cfg_q[bsc_pkg::REG_KEY_1];
		in_blk[6]  = cfg_q[bsc_pkg::REG_KEY_2];
		in_blk[7]  = cfg_q[bsc_pkg::REG_KEY_3];
		for (int i = 0; i < 5; i++) begin
			in_blk[8 + i] = bsc_pkg::FIXED_WORDS[4 + i];
		end
		in_blk[13] = counter_q;
		in_blk[14] = cfg_q[bsc_pkg::REG_NONCE_0];
		in_blk[15] = cfg_q[bsc_pkg::REG_NONCE_1];
	end

	// Gather the four lanes of this phase: columns or diagonals
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			lane_sel[l] = cmd.phase[1] ? bsc_pkg::QR_SEL[4 + l] : bsc_pkg::QR_SEL[l];
			lane_a[l]   = x_q[lane_sel[l][3:0]];
			lane_b[l]   = x_q[lane_sel[l][7:4]];
			lane_c[l]   = x_q[lane_sel[l][11:8]];
			lane_d[l]   = x_q[lane_sel[l][15:12]];
		end
	end

	for (genvar l = 0; l < 4; l++) begin : g_lane
		bsc_qround u_qround (
			.half  (cmd.phase[0]),
			.a     (lane_a[l]),
			.b     (lane_b[l]),
			.c     (lane_c[l]),
			.d     (lane_d[l]),
			.a_nxt (lane_an[l]),
			.b_nxt (lane_bn[l]),
			.c_nxt (lane_cn[l]),
			.d_nxt (lane_dn[l])
		);
	end

	// Scatter lane results back; lanes of one phase touch disjoint words
	always_comb begin
		x_rnd = x_q;
		for (int l = 0; l < 4; l++) begin
			x_rnd[lane_sel[l][3:0]]   = lane_an[l];
			x_rnd[lane_sel[l][7:4]]   = lane_bn[l];
			x_rnd[lane_sel[l][11:8]]  = lane_cn[l];
			x_rnd[lane_sel[l][15:12]] = lane_dn[l];
		end
	end

	// Clamp the byte count; non-last beats always carry a full word
	always_comb begin
		if (!last_item) begin
			count_in = bsc_pkg::BYTES_FULL;
		end else if (byte_count < bsc_pkg::BYTES_MIN) begin
			count_in = bsc_pkg::BYTES_MIN;
		end else if (byte_count > bsc_pkg::BYTES_FULL) begin
			count_in = bsc_pkg::BYTES_FULL;
		end else begin
			count_in = byte_count;
		end
	end

	// XOR with the current keystream word and drop bytes beyond the count
	assign res_raw = data_q ^ x_q[pos_q];
	always_comb begin
		for (int j = 0; j < 8; j++) begin
			res_masked[8*j +: 8] = (4'(j) < count_q) ? res_raw[8*j +: 8] : 8'h00;
		end
	end

	// Config registers, block counter and word position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bsc_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
			counter_q <= 64'd1;
			pos_q     <= '0;
		end else begin
			if (status.cfg_hit) begin
				cfg_q[cfg_index] <= cfg_data;
				counter_q        <= 64'd1;
				pos_q            <= '0;
			end else begin
				if (cmd.feed_fwd) begin
					counter_q <= counter_q + 64'd1;
				end
				if (cmd.emit) begin
					pos_q <= status.block_done ? 4'd0 : pos_q + 4'd1;
				end
			end
		end
	end

	// Working state: load, round, feed forward
	always_ff @(posedge clk) begin
		if (cmd.init_state) begin
			x_q <= in_blk;
		end else if (cmd.do_round) begin
			x_q <= x_rnd;
		end else if (cmd.feed_fwd) begin
			for (int i = 0; i < 16; i++) begin
				x_q[i] <= x_q[i] + in_blk[i];
			end
		end
	end

	// Hold the accepted beat and the outgoing result
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			data_q  <= data_word;
			count_q <= count_in;
			last_q  <= last_item;
		end
		if (cmd.emit) begin
			result_word_q  <= res_masked;
			result_count_q <= count_q;
			result_last_q  <= last_q;
		end
	end

	assign result_word  = result_word_q;
	assign result_count = result_count_q;
	assign result_last  = result_last_q;

endmodule

// ===== rtl/core/bsc_ctrl.sv =====
// Controller: sequences block generation and result hand-off, owns the
// block-ready flag and output valid. Depends on bsc_pkg.
module bsc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  bsc_pkg::status_t  status,
	output bsc_pkg::cmd_t     cmd
);

	bsc_pkg::state_t            state_q;
	bsc_pkg::state_t            state_nxt;
	logic [bsc_pkg::RND_W-1:0]  round_q;
	logic                       block_ready_q;
	logic                       out_valid_q;
	logic                       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.phase      = round_q[1:0];
		in_ready       = 1'b0;
		unique case (state_q)
			bsc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					if (block_ready_q) begin
						state_nxt = bsc_pkg::ST_EMIT;
					end else begin
						cmd.init_state = 1'b1;
						state_nxt      = bsc_pkg::ST_ROUND;
					end
				end
			end
			bsc_pkg::ST_ROUND: begin
				cmd.do_round = 1'b1;
				if (round_q == bsc_pkg::RND_W'(bsc_pkg::ROUND_CYCLES - 1)) begin
					state_nxt = bsc_pkg::ST_FEED;
				end
			end
			bsc_pkg::ST_FEED: begin
				cmd.feed_fwd = 1'b1;
				state_nxt    = bsc_pkg::ST_EMIT;
			end
			bsc_pkg::ST_EMIT: begin
				if (out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = bsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bsc_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsc_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Round counter: clear on block start, advance each round cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.init_state) begin
			round_q <= '0;
		end else if (cmd.do_round) begin
			round_q <= round_q + 1'b1;
		end
	end

	// Block-ready flag: set after feed-forward, drop on exhaustion, last or config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_ready_q <= 1'b0;
		end else if (status.cfg_hit) begin
			block_ready_q <= 1'b0;
		end else if (cmd.feed_fwd) begin
			block_ready_q <= 1'b1;
		end else if (cmd.emit && status.block_done) begin
			block_ready_q <= 1'b0;
		end
	end

	// Output valid: set on emit, clear when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/blabla_stream_cipher_unit.sv =====
// Top level of the BlaBla (64-bit ChaCha) stream cipher unit.
// Depends on bsc_pkg, bsc_ctrl, bsc_datapath (which uses bsc_qround).
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   input   | in_valid / in_ready | data_word[63:0] byte_count[3:0] last_item
//   output  | out_valid/out_ready | result_word[63:0] result_count[3:0] result_last
//   config  | cfg_we              | cfg_index[2:0] cfg_data[63:0]
//
// A beat that finds a keystream block ready is accepted, then emitted.
// A beat that starts a new block is accepted, then runs the rounds
// (four half quarter-round units, two per quarter round, 10 double rounds),
// then the feed-forward, then emit.
// The output register holds a result while the next beat is accepted; the
// emit waits for out_ready only when that register is still full.
// Reset clears config to zero, the counter to one and drops any block.
module blabla_stream_cipher_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                      cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [63:0]                      data_word,
	input  logic [3:0]                       byte_count,
	input  logic                             last_item,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [63:0]                      result_word,
	output logic [3:0]                       result_count,
	output logic                             result_last
);

	bsc_pkg::cmd_t    cmd;
	bsc_pkg::status_t status;

	bsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bsc_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.last_item    (last_item),
		.cmd          (cmd),
		.status       (status),
		.result_word  (result_word),
		.result_count (result_count),
		.result_last  (result_last)
	);

endmodule

// ===== bench/blabla_stream_cipher_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for blabla_stream_cipher_unit: random message traffic,
// key/nonce rewrites between phases, and an in-bench keystream predictor.
// Depends on bsc_pkg and the RTL under rtl/core.
module blabla_stream_cipher_unit_tb;

	localparam int CIPHER_ROUNDS = 10;
	localparam int CFG_COUNT     = 6;
	localparam int FULL_BYTES    = 8;
	localparam logic [bsc_pkg::CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
	localparam logic [bsc_pkg::CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;
	localparam logic [bsc_pkg::CFG_IDX_W-1:0] CFG_MAP [CFG_COUNT] = '{
		bsc_pkg::REG_KEY_0, bsc_pkg::REG_KEY_1, bsc_pkg::REG_KEY_2,
		bsc_pkg::REG_KEY_3, bsc_pkg::REG_NONCE_0, bsc_pkg::REG_NONCE_1
	};
	// State words 0-3, then 8-12
	localparam logic [63:0] SIGMA_WORDS [9] = '{
		64'h6170786593810fab, 64'h3320646ec7398aee,
		64'h79622d3217318274, 64'h6b206574babadada,
		64'h2ae36e593e46ad5f, 64'hb68f143029225fc9,
		64'h8da1e08468303aa6, 64'ha48a209acd50a4a7,
		64'h7fdc12f23f90778c
	};

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  cnt;
		logic        last;
	} plain_beat_t;

	typedef struct packed {
		logic [63:0] word;
		logic [3:0]  cnt;
		logic        last;
	} cipher_beat_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]                   cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [63:0]                   data_word = '0;
	logic [3:0]                    byte_count = '0;
	logic                          last_item = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [63:0]                   result_word;
	logic [3:0]                    result_count;
	logic                          result_last;

	// Predictor state
	logic [63:0] cfg_regs [CFG_COUNT] = '{default: '0};
	logic [63:0] blk_ctr = 64'd1;
	logic [63:0] ks_words [16];
	int          ks_pos = 0;
	bit          ks_valid = 1'b0;

	plain_beat_t  plaintext_q [$];
	cipher_beat_t ciphertext_q [$];

	int src_gap = 0;
	int snk_gap = 0;
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	bit quiet = 1'b0;
	int hold_left = 0;
	int next_hold_at = 150;
	int results_seen = 0;
	int errors = 0;

	blabla_stream_cipher_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result_word (result_word),
		.result_count(result_count),
		.result_last (result_last)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] rot_right(logic [63:0] v, int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	// Build the next 128-byte keystream block and advance the counter
	function automatic void make_keystream();
		logic [63:0] init_w [16];
		logic [63:0] x [16];
		int i, qa, qb, qc, qd;
		for (int k = 0; k < 4; k++) begin
			init_w[k]     = SIGMA_WORDS[k];
			init_w[4 + k] = cfg_regs[k];
		end
		for (int k = 0; k < 5; k++) init_w[8 + k] = SIGMA_WORDS[4 + k];
		init_w[13] = blk_ctr;
		init_w[14] = cfg_regs[4];
		init_w[15] = cfg_regs[5];
		x = init_w;
		for (int r = 0; r < 8 * CIPHER_ROUNDS; r++) begin
			i = r % 4;
			qa = i;
			if ((r % 8) < 4) begin
				qb = i + 4; qc = i + 8; qd = i + 12;
			end else begin
				qb = 4 + (i + 1) % 4; qc = 8 + (i + 2) % 4; qd = 12 + (i + 3) % 4;
			end
			x[qa] += x[qb]; x[qd] = rot_right(x[qd] ^ x[qa], 32);
			x[qc] += x[qd]; x[qb] = rot_right(x[qb] ^ x[qc], 24);
			x[qa] += x[qb]; x[qd] = rot_right(x[qd] ^ x[qa], 16);
			x[qc] += x[qd]; x[qb] = rot_right(x[qb] ^ x[qc], 63);
		end
		for (int k = 0; k < 16; k++) ks_words[k] = x[k] + init_w[k];
		blk_ctr += 64'd1;
	endfunction

	// Work out the ciphertext beat for one accepted plaintext beat
	function automatic void encrypt_beat(logic [63:0] data, logic [3:0] cnt, logic last);
		cipher_beat_t r;
		int unsigned n;
		if (!ks_valid) begin
			make_keystream();
			ks_pos = 0;
			ks_valid = 1'b1;
		end
		r.word = data ^ ks_words[ks_pos];
		r.last = last;
		n = cnt;
		if (!last) n = FULL_BYTES;
		else if (n < 1) n = 1;
		else if (n > FULL_BYTES) n = FULL_BYTES;
		if (n < FULL_BYTES) r.word &= (64'd1 << (8 * n)) - 64'd1;
		r.cnt = 4'(n);
		ks_pos++;
		if (ks_pos == 16 || last) begin
			ks_pos = 0;
			ks_valid = 1'b0;
		end
		ciphertext_q.push_back(r);
	endfunction

	// Drive plaintext beats; predict each one as it is accepted
	always @(posedge clk) begin
		plain_beat_t nxt;
		if (arst_n && !(in_valid && !in_ready)) begin
			if (in_valid) encrypt_beat(data_word, byte_count, last_item);
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				in_valid <= 1'b0;
			end else if (plaintext_q.size() != 0) begin
				nxt = plaintext_q.pop_front();
				data_word  <= nxt.data;
				byte_count <= nxt.cnt;
				last_item  <= nxt.last;
				in_valid   <= 1'b1;
				if (!quiet && $urandom_range(0, 99) < src_idle_pct)
					src_gap <= $urandom_range(1, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off while plaintext is still queued, so the input backs up
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!quiet && results_seen >= next_hold_at && plaintext_q.size() > 40) begin
			hold_left <= 400;
			next_hold_at <= results_seen + 700;
		end
	end

	// Check ciphertext beats against the oldest prediction; pace out_ready
	always @(posedge clk) begin
		cipher_beat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (ciphertext_q.size() == 0) begin
					$error("unexpected beat: result_word %h", result_word);
					errors++;
				end else begin
					want = ciphertext_q.pop_front();
					if (result_word !== want.word) begin
						$error("result_word: expected %h, got %h", want.word, result_word);
						errors++;
					end
					if (result_count !== want.cnt) begin
						$error("result_count: expected %0d, got %0d", want.cnt, result_count);
						errors++;
					end
					if (result_last !== want.last) begin
						$error("result_last: expected %0b, got %0b", want.last, result_last);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (snk_gap != 0) begin
				snk_gap <= snk_gap - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < snk_idle_pct) begin
				snk_gap <= $urandom_range(0, 9);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void push_beat(logic [63:0] data, logic [3:0] cnt, logic last);
		plain_beat_t b;
		b.data = data;
		b.cnt  = cnt;
		b.last = last;
		plaintext_q.push_back(b);
	endfunction

	// Queue a message; an open one has no closing beat
	function automatic void push_message(int len, bit open_end);
		for (int k = 0; k < len; k++)
			push_beat(rand_word(), 4'($urandom_range(0, 15)), !open_end && k == len - 1);
	endfunction

	// Hold until every queued beat has gone in and every result has come out
	task automatic drain();
		while (plaintext_q.size() != 0 || in_valid || ciphertext_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [bsc_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < CFG_COUNT) begin
			cfg_regs[idx] = val;
			blk_ctr  = 64'd1;
			ks_pos   = 0;
			ks_valid = 1'b0;
		end
	endtask

	task automatic run_phase(int n_items);
		int len;
		while (n_items > 0) begin
			case ($urandom_range(0, 5))
				0: len = 1;
				1: len = 16;
				2: len = 17;
				default: len = $urandom_range(2, 40);
			endcase
			if (len > n_items) len = n_items;
			n_items -= len;
			push_message(len, n_items == 0 && $urandom_range(0, 1));
		end
		drain();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats on the all-zero reset key
		src_idle_pct = 20;
		snk_idle_pct = 20;
		push_beat(64'h0, 4'd0, 1'b1);
		push_beat('1, 4'd15, 1'b1);
		push_beat('1, 4'd8, 1'b1);
		push_beat('1, 4'd1, 1'b1);
		push_beat('1, 4'd4, 1'b1);
		push_beat('1, 4'd7, 1'b1);
		// Cross a block boundary; counts on inner beats are ignored
		for (int k = 0; k < 16; k++)
			push_beat(rand_word(), 4'(k), 1'b0);
		push_beat(rand_word(), 4'd4, 1'b1);
		// Leave a message open, poke an unmapped register, then finish it
		push_beat(rand_word(), 4'd3, 1'b0);
		drain();
		write_reg(REG_UNUSED_6, rand_word());
		push_beat(rand_word(), 4'd6, 1'b1);
		drain();
		write_reg(REG_UNUSED_7, '1);

		// Random phases under changing key and nonce
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: for (int r = 0; r < CFG_COUNT; r++) write_reg(CFG_MAP[r], '1);
				1: for (int r = 0; r < CFG_COUNT; r++)
					write_reg(CFG_MAP[r], r[0] ? 64'h5555555555555555 : 64'haaaaaaaaaaaaaaaa);
				3, 5: write_reg(CFG_MAP[$urandom_range(0, CFG_COUNT - 1)], rand_word());
				default: for (int r = 0; r < CFG_COUNT; r++) write_reg(CFG_MAP[r], rand_word());
			endcase
			if ($urandom_range(0, 2) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7, rand_word());
			case ($urandom_range(0, 2))
				0: src_idle_pct = 0;
				1: src_idle_pct = 15;
				default: src_idle_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: snk_idle_pct = 0;
				1: snk_idle_pct = 15;
				default: snk_idle_pct = 40;
			endcase
			if (p == 7) quiet = 1'b1;
			run_phase(230);
		end

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== blabla_stream_cipher_unit.f =====
rtl/core/bsc_pkg.sv
rtl/core/bsc_qround.sv
rtl/core/bsc_datapath.sv
rtl/core/bsc_ctrl.sv
rtl/core/blabla_stream_cipher_unit.sv
bench/blabla_stream_cipher_unit_tb.sv
